// ----- sv/akh_pkg.sv -----
// ----------------------------------------------------------------------------
// akh_pkg
// Types, codes and constants shared by the analog key scanner files.
// ----------------------------------------------------------------------------
package akh_pkg;

  localparam int KEY_COUNT  = 16;
  localparam int ADDR_W     = 4;
  localparam int KEY_W      = 4;
  localparam int SAMPLE_FW  = 12;  // converter field width on the port
  localparam int REG_W      = 12;  // widest configuration register
  localparam int CFG_IDX_W  = 2;

  localparam logic [REG_W-1:0] PRESS_THRESHOLD_RESET    = 12'd35;
  localparam logic [REG_W-1:0] RELEASE_HYSTERESIS_RESET = 12'd12;
  localparam logic             ANALOG_ENABLE_RESET      = 1'b1;

  // mux address to logical key index
  localparam logic [KEY_W-1:0] ADDR_TO_KEY [KEY_COUNT] = '{
    4'd3, 4'd12, 4'd13, 4'd14, 4'd8, 4'd9, 4'd4, 4'd10,
    4'd5, 4'd11, 4'd15, 4'd6, 4'd7, 4'd0, 4'd1, 4'd2
  };

  typedef enum logic {
    OP_CAL  = 1'b0,
    OP_SCAN = 1'b1
  } akh_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESS_THRESHOLD    = 2'd0,
    REG_RELEASE_HYSTERESIS = 2'd1,
    REG_ANALOG_ENABLE      = 2'd2
  } akh_reg_t;

  typedef struct packed {
    akh_op_t              op;
    logic [ADDR_W-1:0]    key_address;
    logic [SAMPLE_FW-1:0] adc_sample;
    logic                 last_in_scan;
  } akh_in_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key_pos;
    logic                 key_pressed;
    logic                 baseline_done;
    logic                 scan_done;
    logic [KEY_COUNT-1:0] key_matrix;
    logic                 matrix_changed;
  } akh_out_t;

  typedef struct packed {
    akh_reg_t         index;
    logic [REG_W-1:0] value;
  } akh_cfg_t;

  typedef struct packed {
    logic [REG_W-1:0] press_threshold;
    logic [REG_W-1:0] release_hysteresis;
    logic             analog_enable;
  } akh_regs_t;

endpackage

// ----- sv/akh_stream_if.sv -----
// ----------------------------------------------------------------------------
// akh_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface akh_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/akh_core.sv -----
// ----------------------------------------------------------------------------
// akh_core
// Key state: baselines, calibration sum, pressed flags and matrix. Computes
// the result of one item and updates the state when the item advances.
// ----------------------------------------------------------------------------
module akh_core #(
  parameter int CAL_SAMPLES = 4,
  parameter int ADC_BITS    = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  akh_pkg::akh_in_t    item,
  input  akh_pkg::akh_regs_t  regs,
  output akh_pkg::akh_out_t   result
);

  localparam int SAMPLE_W  = (ADC_BITS < akh_pkg::SAMPLE_FW) ? ADC_BITS : akh_pkg::SAMPLE_FW;
  localparam int CNT_BITS  = $clog2(CAL_SAMPLES);
  localparam int CNT_W     = (CNT_BITS > 0) ? CNT_BITS : 1;
  localparam int ACC_W     = SAMPLE_W + CNT_BITS;
  // exact floor division by reciprocal: ceil(2^(ACC_W+CNT_BITS) / CAL_SAMPLES)
  localparam int DIV_SH    = ACC_W + CNT_BITS;
  localparam int RCP_W     = ACC_W + 1;
  localparam int PROD_W    = ACC_W + RCP_W;
  localparam int RECIP     = ((1 << DIV_SH) + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam int CMP_W     = akh_pkg::REG_W + 1;
  localparam int KC        = akh_pkg::KEY_COUNT;

  logic [SAMPLE_W-1:0] baseline_r [KC];
  logic [KC-1:0]       flags_r;
  logic [ACC_W-1:0]    acc_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [KC-1:0]       build_r;
  logic [KC-1:0]       report_r;

  logic [SAMPLE_W-1:0]       sample;
  logic [SAMPLE_W-1:0]       base;
  logic [akh_pkg::KEY_W-1:0] key;
  logic [ACC_W-1:0]          sum;
  logic                      cal_done;
  logic [PROD_W-1:0]         prod;
  logic [SAMPLE_W-1:0]       quot;
  logic [SAMPLE_W-1:0]       mag;
  logic                      above_thr;
  logic                      below_rel;
  logic                      is_scan;
  logic                      pressed;
  logic                      scan_last;
  logic [KC-1:0]             build_nxt;

  always_comb begin
    sample    = item.adc_sample[SAMPLE_W-1:0];
    base      = baseline_r[item.key_address];
    key       = akh_pkg::ADDR_TO_KEY[item.key_address];
    sum       = acc_r + ACC_W'(sample);
    cal_done  = (cnt_r == CNT_W'(CAL_SAMPLES - 1));
    prod      = PROD_W'(sum) * PROD_W'(RECIP);
    quot      = prod[DIV_SH +: SAMPLE_W];
    mag       = (sample >= base) ? (sample - base) : (base - sample);
    above_thr = CMP_W'(mag) > CMP_W'(regs.press_threshold);
    // a negative release bound never releases
    below_rel = (regs.release_hysteresis <= regs.press_threshold) &&
                (CMP_W'(mag) < CMP_W'(regs.press_threshold - regs.release_hysteresis));
    is_scan   = (item.op == akh_pkg::OP_SCAN);
    pressed   = is_scan && regs.analog_enable &&
                (above_thr || (flags_r[key] && !below_rel));
    build_nxt = pressed ? (build_r | (KC'(1) << key)) : build_r;
    scan_last = is_scan && item.last_in_scan;

    result.key_pos        = key;
    result.key_pressed    = pressed;
    result.baseline_done  = !is_scan && cal_done;
    result.scan_done      = scan_last;
    result.key_matrix     = scan_last ? build_nxt : '0;
    result.matrix_changed = scan_last && (build_nxt != report_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KC; i++) begin
        baseline_r[i] <= '0;
      end
      flags_r  <= '0;
      acc_r    <= '0;
      cnt_r    <= '0;
      build_r  <= '0;
      report_r <= '0;
    end else if (fire) begin
      if (!is_scan) begin
        if (cal_done) begin
          baseline_r[item.key_address] <= quot;
          acc_r <= '0;
          cnt_r <= '0;
        end else begin
          acc_r <= sum;
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end else begin
        flags_r[key] <= pressed;
        if (scan_last) begin
          report_r <= build_nxt;
          build_r  <= '0;
        end else begin
          build_r <= build_nxt;
        end
      end
    end
  end

endmodule

// ----- sv/analog_key_hysteresis_scanner.sv -----
// ----------------------------------------------------------------------------
// analog_key_hysteresis_scanner
// Sixteen-key analog scanner with calibrated baselines, press threshold and
// release hysteresis; one result item per sample item.
// ----------------------------------------------------------------------------
// result path: input register, then core result written into a two-entry output
// buffer. Throughput: one item per cycle unless the output buffer is full;
// the state update is a single pass in akh_core.
// in_if.ready depends only on registers, never on out_if.ready.
// reset: synchronous, clears baselines, pressed flags, matrices, calibration
// sum and restores the register defaults; no clearing pass.
module analog_key_hysteresis_scanner #(
  parameter int CAL_SAMPLES = 4,
  parameter int ADC_BITS    = 12
) (
  input logic          clk,
  input logic          rst_n,
  akh_stream_if.sink   in_if,
  akh_stream_if.source out_if,
  akh_stream_if.sink   cfg_if
);

  localparam int BUF_DEPTH = 2;

  akh_pkg::akh_regs_t regs_r;
  akh_pkg::akh_in_t   s1_item_r;
  logic               s1_valid_r;
  akh_pkg::akh_out_t  core_out;
  akh_pkg::akh_out_t  buf0_r;
  akh_pkg::akh_out_t  buf1_r;
  logic [1:0]         buf_cnt_r;
  logic               buf_full;
  logic               in_fire;
  logic               s1_fire;
  logic               pop;
  akh_pkg::akh_cfg_t  cfg_data;

  assign cfg_if.ready = 1'b1;
  assign cfg_data     = cfg_if.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.press_threshold    <= akh_pkg::PRESS_THRESHOLD_RESET;
      regs_r.release_hysteresis <= akh_pkg::RELEASE_HYSTERESIS_RESET;
      regs_r.analog_enable      <= akh_pkg::ANALOG_ENABLE_RESET;
    end else if (cfg_if.valid) begin
      case (cfg_data.index)
        akh_pkg::REG_PRESS_THRESHOLD:    regs_r.press_threshold    <= cfg_data.value;
        akh_pkg::REG_RELEASE_HYSTERESIS: regs_r.release_hysteresis <= cfg_data.value;
        akh_pkg::REG_ANALOG_ENABLE:      regs_r.analog_enable      <= cfg_data.value[0];
        default: ;
      endcase
    end
  end

  assign buf_full    = (buf_cnt_r == 2'(BUF_DEPTH));
  assign s1_fire     = s1_valid_r && !buf_full;
  assign in_if.ready = !s1_valid_r || !buf_full;
  assign in_fire     = in_if.valid && in_if.ready;
  assign pop         = out_if.valid && out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
    if (in_fire) begin
      s1_item_r <= in_if.data;
    end
  end

  akh_core #(
    .CAL_SAMPLES (CAL_SAMPLES),
    .ADC_BITS    (ADC_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_fire),
    .item   (s1_item_r),
    .regs   (regs_r),
    .result (core_out)
  );

  // two-entry output buffer, head in buf0_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r <= '0;
    end else begin
      case ({s1_fire, pop})
        2'b10:   buf_cnt_r <= buf_cnt_r + 2'd1;
        2'b01:   buf_cnt_r <= buf_cnt_r - 2'd1;
        default: buf_cnt_r <= buf_cnt_r;
      endcase
    end
    if (s1_fire && (pop || buf_cnt_r == 2'd0)) begin
      buf0_r <= core_out;
    end else if (pop) begin
      buf0_r <= buf1_r;
    end
    if (s1_fire && !pop && buf_cnt_r == 2'd1) begin
      buf1_r <= core_out;
    end
  end

  assign out_if.valid = (buf_cnt_r != 2'd0);
  assign out_if.data  = buf0_r;

endmodule
